// ----- sv/pdas_pkg.sv -----
`timescale 1ns / 1ps
package pdas_pkg;

   localparam int ONE_Q15 = 32768;
   localparam int BLEND_W = 48;      // exact blend width
   localparam int ROOT_W  = 32;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_ADVECT = 2'd1,
      OP_PICK   = 2'd2,
      OP_CHECK  = 2'd3
   } op_type;

   typedef struct packed {
      logic               valid;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } entry_type;

   typedef struct packed {
      logic start;
      logic pick_mode;   // root of squares << 26 only, no unit vector
   } norm_cmd_type;

   typedef struct packed {
      logic              done;
      logic              nonzero;
      logic [ROOT_W-1:0] root;
   } norm_status_type;

endpackage

// ----- sv/peak_direction_advection_step.sv -----
`timescale 1ns / 1ps
// Peak direction advection step.
// Request channel (req_*): one operation per item - write a peak, advect,
// random pick, or check an entry. Response channel (rsp_*): one item per
// request except writes, which give none. csr_* writes puncture_weight
// (Q1.15, saturated at 1.0); it is always ready and should be written idle.
// Items are handled one at a time; a write is finished once it is taken,
// and a check reads at most one store entry. Advect and pick read the
// voxel's peaks one store read at a time; each valid peak costs a
// normalize pass: for advect, one-bit scaling of the vector, then squaring
// of the three components, a bit-serial square root and, for advect,
// restoring division of each component plus a dot product. Advect adds a
// blend and a final normalize pass; pick adds a weighting step and a scan
// over the peak norms.
// A finished result sits in an output register; a new request is taken
// while it waits, and the next result holds until rsp_ready frees it.
// Reset clears control state, rsp_valid and puncture_weight; the peak store
// is not cleared and must be written before it is read.
module peak_direction_advection_step #(
   parameter int STORE_DEPTH     = 4096,
   parameter int PEAKS_PER_VOXEL = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [11:0]        req_address,
   input  logic signed [15:0] req_vec_x,
   input  logic signed [15:0] req_vec_y,
   input  logic signed [15:0] req_vec_z,
   input  logic               req_peak_present,
   input  logic [15:0]        req_anisotropy,
   input  logic [15:0]        req_random_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic               rsp_found,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_puncture_weight
);

   localparam int AW = (STORE_DEPTH > 2) ? $clog2(STORE_DEPTH) : 1;
   localparam int CW = $clog2(PEAKS_PER_VOXEL + 1);
   localparam int IW = (PEAKS_PER_VOXEL > 1) ? $clog2(PEAKS_PER_VOXEL) : 1;
   localparam int W  = pdas_pkg::BLEND_W;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_READ   = 12'b000000000010,
      S_EVAL   = 12'b000000000100,
      S_NORM   = 12'b000000001000,
      S_DOT    = 12'b000000010000,
      S_CMP    = 12'b000000100000,
      S_BLEND  = 12'b000001000000,
      S_FSTART = 12'b000010000000,
      S_FNORM  = 12'b000100000000,
      S_PW     = 12'b001000000000,
      S_PSEL   = 12'b010000000000,
      S_DONE   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   // item fields
   pdas_pkg::op_type   op_ff, op_in;
   logic [11:0]        addr_ff, addr_in;
   logic signed [15:0] d_ff [3];
   logic signed [15:0] d_in [3];
   logic [15:0]        f_ff, f_in;
   logic [15:0]        rv_ff, rv_in;
   logic [15:0]        pw_ff, pw_in;

   // scan state
   logic [CW-1:0]      i_ff, i_in;
   logic [1:0]         k_ff, k_in;
   logic [1:0]         ph_ff, ph_in;
   logic               have_ff, have_in;
   logic signed [15:0] best_ff [3];
   logic signed [15:0] best_in [3];
   logic signed [33:0] best_dot_ff, best_dot_in;
   logic signed [15:0] n_ff [3];
   logic signed [15:0] n_in [3];
   logic signed [33:0] dot_ff, dot_in;
   logic signed [32:0] t1_ff, t1_in;
   logic signed [33:0] t_ff, t_in;
   logic signed [W-1:0] b_ff [3];
   logic signed [W-1:0] b_in [3];
   logic [31:0]        norms_ff [PEAKS_PER_VOXEL];
   logic [31:0]        norms_in [PEAKS_PER_VOXEL];
   pdas_pkg::entry_type pk_ff [PEAKS_PER_VOXEL];
   pdas_pkg::entry_type pk_in [PEAKS_PER_VOXEL];
   logic [31:0]        sum_ff, sum_in;
   logic [31:0]        w_ff, w_in;
   logic [31:0]        cum_ff, cum_in;
   logic [IW-1:0]      j_ff, j_in;

   // result
   logic signed [15:0] res_ff [3];
   logic signed [15:0] res_in [3];
   logic               fnd_ff, fnd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] out_ff [3];
   logic signed [15:0] out_in [3];
   logic               ofound_ff, ofound_in;

   // store and normalizer hookup
   logic                   wr_en;
   pdas_pkg::entry_type    wr_data;
   logic                   rd_en;
   logic [12:0]            idx;
   logic                   idx_ok;
   pdas_pkg::entry_type    rd_data;
   pdas_pkg::norm_cmd_type ncmd;
   pdas_pkg::norm_status_type nstat;
   logic signed [W-1:0]    na_x, na_y, na_z;
   logic signed [15:0]     no_x, no_y, no_z;

   logic                   accept;
   logic signed [16:0]     pwc, cpw, fc, cf;
   logic signed [33:0]     absdot;
   logic [31:0]            cum_next;
   logic [47:0]            wprod;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   assign idx    = {1'b0, addr_ff} + 13'(i_ff);
   assign idx_ok = (32'(idx) < 32'(STORE_DEPTH));

   assign wr_en   = accept && (pdas_pkg::op_type'(req_operation) == pdas_pkg::OP_WRITE)
                    && (32'(req_address) < 32'(STORE_DEPTH));
   assign wr_data = '{valid: req_peak_present, x: req_vec_x, y: req_vec_y, z: req_vec_z};

   pdas_store #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_address)),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (AW'(idx)),
      .rd_data (rd_data)
   );

   // peaks go in as read, the blend after it is formed
   assign na_x = (state_ff == S_EVAL) ? W'(rd_data.x) : b_ff[0];
   assign na_y = (state_ff == S_EVAL) ? W'(rd_data.y) : b_ff[1];
   assign na_z = (state_ff == S_EVAL) ? W'(rd_data.z) : b_ff[2];

   pdas_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .cmd    (ncmd),
      .a_x    (na_x),
      .a_y    (na_y),
      .a_z    (na_z),
      .status (nstat),
      .o_x    (no_x),
      .o_y    (no_y),
      .o_z    (no_z)
   );

   always_comb begin
      pwc      = $signed({1'b0, pw_ff});
      cpw      = 17'sd32768 - pwc;
      fc       = $signed({1'b0, f_ff});
      cf       = 17'sd32768 - fc;
      absdot   = dot_ff[33] ? -dot_ff : dot_ff;
      cum_next = cum_ff + norms_ff[j_ff];
      wprod    = 48'(rv_ff) * 48'(sum_ff);

      state_in     = state_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      d_in         = d_ff;
      f_in         = f_ff;
      rv_in        = rv_ff;
      pw_in        = pw_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      ph_in        = ph_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      best_dot_in  = best_dot_ff;
      n_in         = n_ff;
      dot_in       = dot_ff;
      t1_in        = t1_ff;
      t_in         = t_ff;
      b_in         = b_ff;
      norms_in     = norms_ff;
      pk_in        = pk_ff;
      sum_in       = sum_ff;
      w_in         = w_ff;
      cum_in       = cum_ff;
      j_in         = j_ff;
      res_in       = res_ff;
      fnd_in       = fnd_ff;
      out_in       = out_ff;
      ofound_in    = ofound_ff;
      rd_en        = 1'b0;
      ncmd.start     = 1'b0;
      ncmd.pick_mode = (op_ff == pdas_pkg::OP_PICK);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_valid) begin
         pw_in = (csr_puncture_weight > 16'(pdas_pkg::ONE_Q15))
                 ? 16'(pdas_pkg::ONE_Q15) : csr_puncture_weight;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept && pdas_pkg::op_type'(req_operation) != pdas_pkg::OP_WRITE) begin
               op_in   = pdas_pkg::op_type'(req_operation);
               addr_in = req_address;
               d_in[0] = req_vec_x;
               d_in[1] = req_vec_y;
               d_in[2] = req_vec_z;
               f_in    = (req_anisotropy > 16'(pdas_pkg::ONE_Q15))
                         ? 16'(pdas_pkg::ONE_Q15) : req_anisotropy;
               rv_in   = req_random_value;
               i_in    = '0;
               have_in = 1'b0;
               sum_in  = '0;
               best_dot_in = '0;
               for (int c = 0; c < 3; c++) best_in[c] = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (idx_ok && (i_ff != CW'(PEAKS_PER_VOXEL))) begin
               rd_en    = 1'b1;
               state_in = S_EVAL;
            end else if (op_ff == pdas_pkg::OP_CHECK) begin
               for (int c = 0; c < 3; c++) res_in[c] = '0;
               fnd_in   = 1'b0;
               state_in = S_DONE;
            end else if (op_ff == pdas_pkg::OP_ADVECT) begin
               k_in     = '0;
               ph_in    = '0;
               state_in = S_BLEND;
            end else if (i_ff == '0) begin
               for (int c = 0; c < 3; c++) res_in[c] = '0;
               fnd_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               state_in = S_PW;
            end
         end
         S_EVAL: begin
            if (op_ff == pdas_pkg::OP_CHECK) begin
               for (int c = 0; c < 3; c++) res_in[c] = '0;
               fnd_in   = rd_data.valid;
               state_in = S_DONE;
            end else if (!rd_data.valid) begin
               // scan ends at the first empty slot; i_ff keeps the peak count
               if (op_ff == pdas_pkg::OP_ADVECT) begin
                  k_in     = '0;
                  ph_in    = '0;
                  state_in = S_BLEND;
               end else if (i_ff == '0) begin
                  for (int c = 0; c < 3; c++) res_in[c] = '0;
                  fnd_in   = 1'b0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_PW;
               end
            end else begin
               pk_in[IW'(i_ff)] = rd_data;
               ncmd.start = 1'b1;
               state_in   = S_NORM;
            end
         end
         S_NORM: begin
            if (nstat.done) begin
               if (op_ff == pdas_pkg::OP_PICK) begin
                  norms_in[IW'(i_ff)] = nstat.root;
                  sum_in   = sum_ff + nstat.root;
                  i_in     = i_ff + CW'(1);
                  state_in = S_READ;
               end else begin
                  n_in[0]  = no_x;
                  n_in[1]  = no_y;
                  n_in[2]  = no_z;
                  dot_in   = '0;
                  k_in     = '0;
                  state_in = S_DOT;
               end
            end
         end
         S_DOT: begin
            dot_in = dot_ff + 34'(n_ff[k_ff]) * 34'(d_ff[k_ff]);
            k_in   = k_ff + 2'd1;
            if (k_ff == 2'd2) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            // flip toward the incoming direction; first peak wins a tie
            if (!have_ff || absdot > best_dot_ff) begin
               have_in     = 1'b1;
               best_dot_in = absdot;
               for (int c = 0; c < 3; c++) begin
                  best_in[c] = dot_ff[33] ? -n_ff[c] : n_ff[c];
               end
            end
            i_in     = i_ff + CW'(1);
            state_in = S_READ;
         end
         S_BLEND: begin
            case (ph_ff)
               2'd0: begin
                  t1_in = 33'(cpw) * 33'(d_ff[k_ff]);
                  ph_in = 2'd1;
               end
               2'd1: begin
                  t_in  = 34'(t1_ff) + 34'(pwc) * 34'(best_ff[k_ff]);
                  ph_in = 2'd2;
               end
               default: begin
                  b_in[k_ff] = W'(cf) * W'(t_ff) + ((W'(fc) * W'(best_ff[k_ff])) <<< 15);
                  ph_in = 2'd0;
                  k_in  = k_ff + 2'd1;
                  if (k_ff == 2'd2) begin
                     state_in = S_FSTART;
                  end
               end
            endcase
         end
         S_FSTART: begin
            ncmd.start     = 1'b1;
            ncmd.pick_mode = 1'b0;
            state_in       = S_FNORM;
         end
         S_FNORM: begin
            if (nstat.done) begin
               res_in[0] = no_x;
               res_in[1] = no_y;
               res_in[2] = no_z;
               fnd_in    = nstat.nonzero;
               state_in  = S_DONE;
            end
         end
         S_PW: begin
            w_in     = wprod[47:16];
            cum_in   = '0;
            j_in     = '0;
            state_in = S_PSEL;
         end
         S_PSEL: begin
            if (w_ff < cum_next || (CW'(j_ff) + CW'(1)) == i_ff) begin
               res_in[0] = pk_ff[j_ff].x;
               res_in[1] = pk_ff[j_ff].y;
               res_in[2] = pk_ff[j_ff].z;
               fnd_in    = 1'b1;
               state_in  = S_DONE;
            end else begin
               cum_in = cum_next;
               j_in   = j_ff + IW'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_in       = res_ff;
               ofound_in    = fnd_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pw_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pw_ff        <= pw_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      d_ff        <= d_in;
      f_ff        <= f_in;
      rv_ff       <= rv_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      ph_ff       <= ph_in;
      have_ff     <= have_in;
      best_ff     <= best_in;
      best_dot_ff <= best_dot_in;
      n_ff        <= n_in;
      dot_ff      <= dot_in;
      t1_ff       <= t1_in;
      t_ff        <= t_in;
      b_ff        <= b_in;
      norms_ff    <= norms_in;
      pk_ff       <= pk_in;
      sum_ff      <= sum_in;
      w_ff        <= w_in;
      cum_ff      <= cum_in;
      j_ff        <= j_in;
      res_ff      <= res_in;
      fnd_ff      <= fnd_in;
      out_ff      <= out_in;
      ofound_ff   <= ofound_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];
   assign rsp_found = ofound_ff;

endmodule

// ----- sv/pdas_store.sv -----
`timescale 1ns / 1ps
module pdas_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  pdas_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output pdas_pkg::entry_type rd_data
);

   pdas_pkg::entry_type mem [DEPTH];
   pdas_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pdas_isqrt.sv -----
`timescale 1ns / 1ps
module pdas_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] s_ff, s_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] trial;

   // one result bit per cycle
   always_comb begin
      trial   = res_ff + bit_ff;
      s_in    = s_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         s_in    = value;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (s_ff >= trial) begin
            s_in   = s_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff    <= s_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

// ----- sv/pdas_norm.sv -----
`timescale 1ns / 1ps
module pdas_norm (
   input  logic                              clock,
   input  logic                              reset,
   input  pdas_pkg::norm_cmd_type            cmd,
   input  logic signed [pdas_pkg::BLEND_W-1:0] a_x,
   input  logic signed [pdas_pkg::BLEND_W-1:0] a_y,
   input  logic signed [pdas_pkg::BLEND_W-1:0] a_z,
   output pdas_pkg::norm_status_type         status,
   output logic signed [15:0]                o_x,
   output logic signed [15:0]                o_y,
   output logic signed [15:0]                o_z
);

   localparam int W = pdas_pkg::BLEND_W;

   typedef enum logic [6:0] {
      N_IDLE   = 7'b0000001,
      N_SHIFT  = 7'b0000010,
      N_SQ     = 7'b0000100,
      N_RSTART = 7'b0001000,
      N_ROOT   = 7'b0010000,
      N_DLOAD  = 7'b0100000,
      N_DIV    = 7'b1000000
   } nstate_type;

   nstate_type        state_ff, state_in;
   logic [W-1:0]      m_ff [3];
   logic [W-1:0]      m_in [3];
   logic              neg_ff [3];
   logic              neg_in [3];
   logic              pick_ff, pick_in;
   logic [1:0]        k_ff, k_in;
   logic [61:0]       acc_ff, acc_in;
   logic [31:0]       r_ff, r_in;
   logic [44:0]       rem_ff, rem_in;
   logic [44:0]       dv_ff, dv_in;
   logic [13:0]       q_ff, q_in;
   logic [3:0]        step_ff, step_in;
   logic signed [15:0] o_ff [3];
   logic signed [15:0] o_in [3];
   logic              nz_ff, nz_in;
   logic              done_ff, done_in;
   logic [31:0]       root_ff, root_in;

   logic [W-1:0]      mx;
   logic [W-1:0]      ain [3];
   logic [59:0]       sq;
   logic              sq_start;
   logic [63:0]       sq_value;
   logic              sq_done;
   logic [31:0]       sq_root;
   logic              qbit;
   logic [13:0]       qn;

   pdas_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (sq_value),
      .done  (sq_done),
      .root  (sq_root)
   );

   always_comb begin
      ain[0] = a_x;
      ain[1] = a_y;
      ain[2] = a_z;
      mx = (m_ff[0] > m_ff[1]) ? m_ff[0] : m_ff[1];
      if (m_ff[2] > mx) begin
         mx = m_ff[2];
      end
      sq       = 60'(m_ff[k_ff][29:0]) * 60'(m_ff[k_ff][29:0]);
      sq_start = (state_ff == N_RSTART);
      sq_value = pick_ff ? (64'(acc_ff) << 26) : 64'(acc_ff);
      qbit     = (rem_ff >= dv_ff);
      qn       = {q_ff[12:0], qbit};

      state_in = state_ff;
      m_in     = m_ff;
      neg_in   = neg_ff;
      pick_in  = pick_ff;
      k_in     = k_ff;
      acc_in   = acc_ff;
      r_in     = r_ff;
      rem_in   = rem_ff;
      dv_in    = dv_ff;
      q_in     = q_ff;
      step_in  = step_ff;
      o_in     = o_ff;
      nz_in    = nz_ff;
      root_in  = root_ff;
      done_in  = 1'b0;

      case (state_ff)
         N_IDLE: begin
            if (cmd.start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = ain[i][W-1];
                  m_in[i]   = ain[i][W-1] ? (~ain[i] + W'(1)) : ain[i];
               end
               pick_in  = cmd.pick_mode;
               acc_in   = '0;
               k_in     = '0;
               state_in = cmd.pick_mode ? N_SQ : N_SHIFT;
            end
         end
         N_SHIFT: begin
            if (mx == '0) begin
               for (int i = 0; i < 3; i++) o_in[i] = '0;
               nz_in    = 1'b0;
               done_in  = 1'b1;
               state_in = N_IDLE;
            end else if (mx < (W'(1) << 29)) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] << 1;
            end else if (mx >= (W'(1) << 30)) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] >> 1;
            end else begin
               state_in = N_SQ;
            end
         end
         N_SQ: begin
            acc_in = acc_ff + 62'(sq);
            k_in   = k_ff + 2'd1;
            if (k_ff == 2'd2) begin
               state_in = N_RSTART;
            end
         end
         N_RSTART: begin
            state_in = N_ROOT;
         end
         N_ROOT: begin
            if (sq_done) begin
               if (pick_ff) begin
                  root_in  = sq_root;
                  done_in  = 1'b1;
                  state_in = N_IDLE;
               end else begin
                  r_in     = sq_root;
                  k_in     = '0;
                  state_in = N_DLOAD;
               end
            end
         end
         N_DLOAD: begin
            // rounded quotient of m * 8192 / r, at most 8192
            rem_in   = 45'({m_ff[k_ff][29:0], 13'b0}) + 45'(r_ff >> 1);
            dv_in    = 45'(r_ff) << 13;
            q_in     = '0;
            step_in  = '0;
            state_in = N_DIV;
         end
         N_DIV: begin
            if (qbit) begin
               rem_in = rem_ff - dv_ff;
            end
            dv_in   = dv_ff >> 1;
            q_in    = qn;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd13) begin
               o_in[k_ff] = neg_ff[k_ff] ? -$signed({2'b0, qn}) : $signed({2'b0, qn});
               if (k_ff == 2'd2) begin
                  nz_in    = 1'b1;
                  done_in  = 1'b1;
                  state_in = N_IDLE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = N_DLOAD;
               end
            end
         end
         default: begin
            state_in = N_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      neg_ff  <= neg_in;
      pick_ff <= pick_in;
      k_ff    <= k_in;
      acc_ff  <= acc_in;
      r_ff    <= r_in;
      rem_ff  <= rem_in;
      dv_ff   <= dv_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      o_ff    <= o_in;
      nz_ff   <= nz_in;
      root_ff <= root_in;
   end

   assign status.done    = done_ff;
   assign status.nonzero = nz_ff;
   assign status.root    = root_ff;
   assign o_x = o_ff[0];
   assign o_y = o_ff[1];
   assign o_z = o_ff[2];

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for peak_direction_advection_step.
// A predictor keeps its own copy of the peak store and of puncture_weight,
// and computes each expected response item at the moment its request item
// is accepted. A checker compares each accepted response item, field by
// field, with the oldest prediction.
// Stimulus: directed cases (field extremes, ties, flipped peaks, empty
// voxels, zero-norm peaks, scans that run off the top of the store), then
// random traffic. The random traffic is mostly voxel sequences (write a
// voxel's peaks, then advect / pick / check on it) plus loose noise items.
// Reads never touch a store entry that was never written.
module testbench;

   localparam int DEPTH      = 4096;
   localparam int PPV        = 3;
   localparam int IDLE_LIMIT = 20000;   // cycles with no handshake at all
   localparam int SETTLE     = 600;     // > one full advect pass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_operation = pdas_pkg::OP_WRITE;
   logic [11:0]        req_address = '0;
   logic signed [15:0] req_vec_x = '0;
   logic signed [15:0] req_vec_y = '0;
   logic signed [15:0] req_vec_z = '0;
   logic               req_peak_present = 1'b0;
   logic [15:0]        req_anisotropy = '0;
   logic [15:0]        req_random_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_out_x;
   logic signed [15:0] rsp_out_y;
   logic signed [15:0] rsp_out_z;
   logic               rsp_found;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [15:0]        csr_puncture_weight = '0;

   peak_direction_advection_step i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_address         (req_address),
      .req_vec_x           (req_vec_x),
      .req_vec_y           (req_vec_y),
      .req_vec_z           (req_vec_z),
      .req_peak_present    (req_peak_present),
      .req_anisotropy      (req_anisotropy),
      .req_random_value    (req_random_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_x           (rsp_out_x),
      .rsp_out_y           (rsp_out_y),
      .rsp_out_z           (rsp_out_z),
      .rsp_found           (rsp_found),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_puncture_weight (csr_puncture_weight)
   );

   always #2 clock = ~clock;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               found;
   } direction_type;

   // predictor state: its own copy of the store and the register
   bit                 mirror_valid [DEPTH];
   bit                 mirror_written [DEPTH];
   logic signed [15:0] mirror_x [DEPTH];
   logic signed [15:0] mirror_y [DEPTH];
   logic signed [15:0] mirror_z [DEPTH];
   logic [15:0]        mirror_weight = '0;

   direction_type pending_dirs [$];
   int errors = 0;
   int items_sent = 0;
   int op_count [4];
   int found_count = 0;
   int idle_cycles = 0;
   int burst_left = 0;

   // ---------------------------------------------------------------- math
   function automatic longint unsigned root64(longint unsigned s);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s   = s - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // unit vector in Q2.13; returns 0 for a zero vector
   function automatic bit unit_vec(input longint a [3], output longint o [3]);
      longint unsigned m [3];
      longint unsigned mx, s, r, q;
      mx = 0;
      s  = 0;
      for (int k = 0; k < 3; k++) begin
         m[k] = (a[k] < 0) ? longint'(-a[k]) : longint'(a[k]);
         if (m[k] > mx) mx = m[k];
         o[k] = 0;
      end
      if (mx == 0) return 1'b0;
      while (mx < (64'd1 << 29)) begin
         mx <<= 1;
         for (int k = 0; k < 3; k++) m[k] <<= 1;
      end
      while (mx >= (64'd1 << 30)) begin
         mx >>= 1;
         for (int k = 0; k < 3; k++) m[k] >>= 1;
      end
      for (int k = 0; k < 3; k++) s += m[k] * m[k];
      r = root64(s);
      for (int k = 0; k < 3; k++) begin
         q    = (m[k] * 8192 + r / 2) / r;
         o[k] = (a[k] < 0) ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   function automatic bit entry_live(int idx);
      return idx < DEPTH && mirror_valid[idx];
   endfunction

   // a scan reads entries until the first invalid one, so every entry it
   // touches must already be written
   function automatic bit scan_is_defined(pdas_pkg::op_type op, int addr);
      if (op == pdas_pkg::OP_CHECK) return mirror_written[addr];
      for (int i = 0; i < PPV; i++) begin
         if (addr + i >= DEPTH) return 1'b1;
         if (!mirror_written[addr + i]) return 1'b0;
         if (!mirror_valid[addr + i]) return 1'b1;
      end
      return 1'b1;
   endfunction

   // Computes the response of one accepted request and updates the mirror.
   task automatic predict_direction(pdas_pkg::op_type op, int addr, logic signed [15:0] vx,
                                    logic signed [15:0] vy, logic signed [15:0] vz,
                                    logic pp, logic [15:0] anis, logic [15:0] rnd);
      direction_type e;
      longint d [3], best [3], v [3], n [3], blend [3], res [3];
      longint best_dot, dot, f, p;
      longint unsigned norms [PPV];
      longint unsigned sum, w, cum;
      bit have;
      int cnt, pick;
      op_count[op]++;
      d[0] = vx; d[1] = vy; d[2] = vz;
      res  = '{0, 0, 0};
      e.found = 1'b0;
      case (op)
         pdas_pkg::OP_WRITE: begin
            mirror_valid[addr]   = pp;
            mirror_written[addr] = 1'b1;
            mirror_x[addr] = vx;
            mirror_y[addr] = vy;
            mirror_z[addr] = vz;
            return;
         end
         pdas_pkg::OP_ADVECT: begin
            f = (anis > pdas_pkg::ONE_Q15) ? pdas_pkg::ONE_Q15 : anis;
            p = (mirror_weight > pdas_pkg::ONE_Q15) ? pdas_pkg::ONE_Q15 : mirror_weight;
            best = '{0, 0, 0};
            best_dot = 0;
            have = 1'b0;
            for (int i = 0; i < PPV; i++) begin
               if (!entry_live(addr + i)) break;
               v[0] = mirror_x[addr + i];
               v[1] = mirror_y[addr + i];
               v[2] = mirror_z[addr + i];
               void'(unit_vec(v, n));
               dot = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
               if (dot < 0) begin          // flip toward the incoming direction
                  for (int k = 0; k < 3; k++) n[k] = -n[k];
                  dot = -dot;
               end
               if (!have || dot > best_dot) begin   // first peak wins a tie
                  have = 1'b1;
                  best_dot = dot;
                  best = n;
               end
            end
            for (int k = 0; k < 3; k++)
               blend[k] = f * pdas_pkg::ONE_Q15 * best[k]
                        + (pdas_pkg::ONE_Q15 - f)
                          * ((pdas_pkg::ONE_Q15 - p) * d[k] + p * best[k]);
            e.found = unit_vec(blend, res);
         end
         pdas_pkg::OP_PICK: begin
            sum = 0;
            cnt = 0;
            for (int i = 0; i < PPV; i++) begin
               if (!entry_live(addr + i)) break;
               v[0] = mirror_x[addr + i];
               v[1] = mirror_y[addr + i];
               v[2] = mirror_z[addr + i];
               norms[i] = root64(longint'(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]) << 26);
               sum += norms[i];
               cnt++;
            end
            if (cnt > 0) begin
               w = (longint'(rnd) * sum) >> 16;
               pick = cnt - 1;        // all norms zero: last valid peak
               cum = 0;
               for (int i = 0; i < cnt; i++) begin
                  cum += norms[i];
                  if (w < cum) begin
                     pick = i;
                     break;
                  end
               end
               res[0] = mirror_x[addr + pick];
               res[1] = mirror_y[addr + pick];
               res[2] = mirror_z[addr + pick];
               e.found = 1'b1;
            end
         end
         default: e.found = entry_live(addr);
      endcase
      e.x = res[0][15:0];
      e.y = res[1][15:0];
      e.z = res[2][15:0];
      if (e.found) found_count++;
      pending_dirs.push_back(e);
   endtask

   // ------------------------------------------------------------ drivers
   // Called at a rising edge; returns at the edge that accepted the item.
   task automatic send_item(pdas_pkg::op_type op, int addr, logic signed [15:0] vx,
                            logic signed [15:0] vy, logic signed [15:0] vz,
                            logic pp, logic [15:0] anis, logic [15:0] rnd);
      bit taken;
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_address      <= addr[11:0];
      req_vec_x        <= vx;
      req_vec_y        <= vy;
      req_vec_z        <= vz;
      req_peak_present <= pp;
      req_anisotropy   <= anis;
      req_random_value <= rnd;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      items_sent++;
      predict_direction(op, addr, vx, vy, vz, pp, anis, rnd);
   endtask

   task automatic put_peak(int addr, int vx, int vy, int vz, bit pp = 1'b1);
      send_item(pdas_pkg::OP_WRITE, addr, vx, vy, vz, pp, 16'd0, 16'd0);
   endtask

   // bursts of items separated by random gaps
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender holds off until every response item is back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_dirs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_weight(logic [15:0] value);
      bit taken;
      drain();
      csr_valid           <= 1'b1;
      csr_puncture_weight <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid     <= 1'b0;
      mirror_weight  = value;
   endtask

   function automatic logic [15:0] pick_component();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sd0;
         3:       return 16'($signed($urandom_range(0, 16)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_weight();
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'd32768;
         2:       return 16'($urandom);          // above 1.0 saturates
         default: return 16'($urandom_range(0, 32768));
      endcase
   endfunction

   // working region: low voxels plus the top of the store
   function automatic int pick_address();
      if ($urandom_range(0, 3) == 0) return $urandom_range(DEPTH - 12, DEPTH - 1);
      return $urandom_range(0, 47);
   endfunction

   // one random item; reads that would touch unwritten entries become writes
   task automatic send_random(pdas_pkg::op_type op, int addr);
      if (op != pdas_pkg::OP_WRITE && !scan_is_defined(op, addr)) op = pdas_pkg::OP_WRITE;
      send_item(op, addr, pick_component(), pick_component(), pick_component(),
                $urandom_range(0, 4) != 0, pick_weight(), 16'($urandom));
   endtask

   // ---------------------------------------------------------- test tasks
   task automatic test_store_extremes();
      put_peak(0, 32767, -32768, 0);
      put_peak(1, -32768, 32767, 32767);
      put_peak(2, 0, 0, 0);                   // valid peak of zero norm
      put_peak(3, 5, 5, 5, 1'b0);             // empty slot marker
      send_item(pdas_pkg::OP_CHECK, 0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'd0, 16'd0);
      send_item(pdas_pkg::OP_CHECK, 3, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'd0, 16'd0);
      put_peak(DEPTH - 2, 100, 0, 0);
      put_peak(DEPTH - 1, 0, 100, 0);         // scan runs off the top
      send_item(pdas_pkg::OP_ADVECT, DEPTH - 1, 16'sd8192, 16'sd0, 16'sd0, 1'b0,
                16'd65535, 16'd0);
      send_item(pdas_pkg::OP_PICK, DEPTH - 2, 16'sd0, 16'sd0, 16'sd0, 1'b0,
                16'd0, 16'd65535);
   endtask

   task automatic test_advect_cases();
      put_peak(8, 8192, 0, 0);
      put_peak(9, 8192, 0, 0);                // tie with first peak
      put_peak(10, 0, -8192, 0);              // flipped toward direction
      put_peak(11, 0, 0, 0, 1'b0);
      send_item(pdas_pkg::OP_ADVECT, 8, 16'sd100, 16'sd0, 16'sd0, 1'b0, 16'd16384, 16'd0);
      send_item(pdas_pkg::OP_ADVECT, 8, 16'sd0, 16'sd9000, 16'sd0, 1'b0, 16'd0, 16'd0);
      send_item(pdas_pkg::OP_ADVECT, 8, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0,
                16'd32768, 16'd0);
      send_item(pdas_pkg::OP_ADVECT, 11, 16'sd0, 16'sd0, 16'sd0, 1'b0,
                16'd1000, 16'd0);             // zero blend
      send_item(pdas_pkg::OP_ADVECT, 11, 16'sh8000, 16'sd3, 16'sd0, 1'b0,
                16'd0, 16'd0);                // no peak
   endtask

   task automatic test_pick_check();
      send_item(pdas_pkg::OP_PICK, 0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'd0, 16'd0);
      send_item(pdas_pkg::OP_PICK, 0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'd0, 16'd65535);
      put_peak(12, 0, 0, 0);
      put_peak(13, 0, 0, 0);
      put_peak(14, 0, 0, 0, 1'b0);
      send_item(pdas_pkg::OP_PICK, 12, 16'sd0, 16'sd0, 16'sd0, 1'b0,
                16'd0, 16'd40000);            // all zero norm
      send_item(pdas_pkg::OP_PICK, 11, 16'sd0, 16'sd0, 16'sd0, 1'b0,
                16'd0, 16'd1234);             // no valid peak
   endtask

   // mostly well-formed voxel sequences with random content, some noise
   task automatic test_random_traffic(int count);
      int stop, base, reads;
      stop = items_sent + count;
      while (items_sent < stop) begin
         if ($urandom_range(0, 9) < 7) begin
            base = pick_address();
            for (int i = 0; i < PPV && base + i < DEPTH; i++) begin
               pace();
               send_random(pdas_pkg::OP_WRITE, base + i);
            end
            reads = $urandom_range(1, 3);
            repeat (reads) begin
               pace();
               send_random(pdas_pkg::op_type'($urandom_range(1, 3)), base);
            end
         end else begin
            pace();
            if ($urandom_range(0, 7) == 0)
               send_random(pdas_pkg::OP_WRITE, $urandom_range(0, DEPTH - 1));
            else
               send_random(pdas_pkg::op_type'($urandom_range(0, 3)), pick_address());
         end
      end
   endtask

   // ------------------------------------------------------ receiver side
   int stall_cycle = 0;
   int stall_mode = 0;
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 256 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= $urandom_range(0, 1);
         2:       rsp_ready <= (stall_cycle % 4 == 0);
         default: rsp_ready <= (stall_cycle % 64) >= 30;   // long stalls
      endcase
   end

   // checker and watchdog, sampled mid-cycle
   always @(negedge clock) begin
      direction_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dirs.size() == 0) begin
            $error("response item with no prediction waiting");
            errors++;
         end else begin
            e = pending_dirs.pop_front();
            if (rsp_out_x !== e.x) begin
               $error("out_x expected %0d actual %0d", e.x, rsp_out_x);
               errors++;
            end
            if (rsp_out_y !== e.y) begin
               $error("out_y expected %0d actual %0d", e.y, rsp_out_y);
               errors++;
            end
            if (rsp_out_z !== e.z) begin
               $error("out_z expected %0d actual %0d", e.z, rsp_out_z);
               errors++;
            end
            if (rsp_found !== e.found) begin
               $error("found expected %0d actual %0d", e.found, rsp_found);
               errors++;
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no handshake in %0d cycles", IDLE_LIMIT);
         $display("testbench: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_store_extremes();        // register still at its reset value
      set_weight(16'd32768);
      test_advect_cases();
      set_weight(16'd65535);        // saturates to 1.0
      test_pick_check();
      set_weight(16'd0);
      test_random_traffic(500);
      set_weight(16'd32768);
      test_random_traffic(500);
      set_weight(16'($urandom_range(1, 32767)));
      test_random_traffic(500);
      set_weight(16'($urandom));
      test_random_traffic(500);
      drain();
      if (pending_dirs.size() != 0) begin
         $error("%0d predicted response items never arrived", pending_dirs.size());
         errors++;
      end
      $display("covered %0d request items: %0d write, %0d advect, %0d pick, %0d check",
               items_sent, op_count[pdas_pkg::OP_WRITE], op_count[pdas_pkg::OP_ADVECT],
               op_count[pdas_pkg::OP_PICK], op_count[pdas_pkg::OP_CHECK]);
      $display("%0d responses had found set; six puncture_weight settings used", found_count);
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/pdas_pkg.sv
sv/pdas_store.sv
sv/pdas_isqrt.sv
sv/pdas_norm.sv
sv/peak_direction_advection_step.sv
sim/testbench.sv
